// ===== hdl/rsd_pkg.sv =====
// Shared types and constants for the record stream deframer.
`default_nettype none

package rsd_pkg;

   // Parse phases of the front end.
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_CONTENT = 2'd1;
   localparam logic [1:0] PH_PADDING = 2'd2;

   // Header byte positions that carry fields we keep.
   localparam logic [2:0] HPOS_KIND   = 3'd1;
   localparam logic [2:0] HPOS_LEN_HI = 3'd4;
   localparam logic [2:0] HPOS_LEN_LO = 3'd5;
   localparam logic [2:0] HPOS_PAD    = 3'd6;
   localparam logic [2:0] HPOS_LAST   = 3'd7;

   // Record types.
   localparam logic [7:0] KIND_END_REQUEST = 8'd3;
   localparam logic [7:0] KIND_STDOUT      = 8'd6;

   // An end-request record always has this many body bytes.
   localparam logic [15:0] END_BODY_BYTES = 16'd8;

   // Result kinds.
   localparam logic RES_BYTE = 1'b0;
   localparam logic RES_END  = 1'b1;

   // Queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // One result item.
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       last;
   } rsd_item_type;

   // Queue status seen by the parser and the output stage.
   typedef struct packed {
      logic full;
      logic empty;
   } rsd_qstat_type;

endpackage

`default_nettype wire

// ===== hdl/rsd_front.sv =====
// Header parser: takes stream bytes and emits result items into the queue.
`default_nettype none

module rsd_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    byte_valid,
   input  wire [7:0]              byte_data,
   input  wire                    queue_full,
   output logic                   byte_ready,
   output logic                   push,
   output rsd_pkg::rsd_item_type  push_item
);
   import rsd_pkg::*;

   logic [1:0]  phase_ff,    phase_in;
   logic [2:0]  hpos_ff,     hpos_in;
   logic [7:0]  kind_ff,     kind_in;
   logic [7:0]  len_hi_ff,   len_hi_in;
   logic [15:0] content_ff,  content_in;
   logic [7:0]  padding_ff,  padding_in;

   logic        take;
   logic [15:0] content_dec;
   logic        content_done;
   logic [7:0]  padding_dec;
   logic [7:0]  kind_now;
   logic [15:0] content_now;
   logic [7:0]  padding_now;

   // A byte is taken whenever the queue has room for a possible result.
   assign byte_ready   = !queue_full;
   assign take         = byte_valid && byte_ready;
   assign content_dec  = content_ff - 16'd1;
   assign content_done = (content_dec == 16'd0);
   assign padding_dec  = padding_ff - 8'd1;

   // Next-state and result logic for one byte.
   always_comb begin
      phase_in   = phase_ff;
      hpos_in    = hpos_ff;
      kind_in    = kind_ff;
      len_hi_in  = len_hi_ff;
      content_in = content_ff;
      padding_in = padding_ff;
      push       = 1'b0;
      push_item  = '{kind: RES_BYTE, data: byte_data, last: content_done};
      kind_now    = kind_ff;
      content_now = content_ff;
      padding_now = padding_ff;

      case (phase_ff)
         PH_CONTENT: begin
            content_in = content_dec;
            if (kind_ff == KIND_STDOUT) begin
               push = take;
            end else if (kind_ff == KIND_END_REQUEST && content_done) begin
               push      = take;
               push_item = '{kind: RES_END, data: 8'd0, last: 1'b1};
            end
            if (content_done) begin
               phase_in = (padding_ff != 8'd0) ? PH_PADDING : PH_HEADER;
            end
         end
         PH_PADDING: begin
            padding_in = padding_dec;
            if (padding_dec == 8'd0) begin
               phase_in = PH_HEADER;
            end
         end
         default: begin
            // Header phase; the unused phase code behaves the same.
            phase_in = PH_HEADER;
            case (hpos_ff)
               HPOS_KIND:   kind_now = byte_data;
               HPOS_LEN_HI: len_hi_in = byte_data;
               HPOS_LEN_LO: content_now = {len_hi_ff, byte_data};
               HPOS_PAD:    padding_now = byte_data;
               default:     ;
            endcase
            kind_in    = kind_now;
            content_in = content_now;
            padding_in = padding_now;
            if (hpos_ff == HPOS_LAST) begin
               hpos_in = 3'd0;
               if (kind_now == KIND_END_REQUEST) begin
                  content_in = END_BODY_BYTES;
               end
               if (content_in != 16'd0) begin
                  phase_in = PH_CONTENT;
               end else begin
                  phase_in = (padding_now != 8'd0) ? PH_PADDING : PH_HEADER;
               end
            end else begin
               hpos_in = hpos_ff + 3'd1;
            end
         end
      endcase
   end

   // Parser state advances on each byte transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hpos_ff    <= 3'd0;
         kind_ff    <= 8'd0;
         len_hi_ff  <= 8'd0;
         content_ff <= 16'd0;
         padding_ff <= 8'd0;
      end else if (take) begin
         phase_ff   <= phase_in;
         hpos_ff    <= hpos_in;
         kind_ff    <= kind_in;
         len_hi_ff  <= len_hi_in;
         content_ff <= content_in;
         padding_ff <= padding_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rsd_queue.sv =====
// Small FIFO between the parser and the output stage.
`default_nettype none

module rsd_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  rsd_pkg::rsd_item_type  push_item,
   input  wire                    pop,
   output rsd_pkg::rsd_item_type  pop_item,
   output rsd_pkg::rsd_qstat_type status
);
   import rsd_pkg::*;

   rsd_item_type        slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff,  count_in;

   assign status.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = slots_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   // The parser never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("push into full queue");

   // The output stage never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("pop from empty queue");

   // The fill count stays within the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("queue count out of range");

   // A lone pop lowers the count by one.
   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not follow a pop");

endmodule

`default_nettype wire

// ===== hdl/rsd_back.sv =====
// Output stage: moves queued items into the result register.
`default_nettype none

module rsd_back (
   input  wire                    clock,
   input  wire                    reset,
   input  rsd_pkg::rsd_qstat_type status,
   input  rsd_pkg::rsd_item_type  pop_item,
   output logic                   pop,
   input  wire                    out_ready,
   output logic                   out_valid,
   output rsd_pkg::rsd_item_type  out_item
);
   import rsd_pkg::*;

   logic         valid_ff, valid_in;
   rsd_item_type item_ff;

   // Load a new item when the register is empty or being drained.
   assign pop       = !status.empty && (!valid_ff || out_ready);
   assign valid_in  = pop || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= pop_item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/record_stream_deframer.sv =====
// Top level of the record stream deframer: parser, queue and output stage.
//
// The req_ channel carries the response byte stream, one byte per transfer.
// The block splits it into records with an 8-byte header (version, type,
// request id, big-endian content length, padding length, reserved).
// STDOUT content bytes leave on the rsp_ channel with rsp_tuser low and
// rsp_tlast high on the final byte of the record. An END_REQUEST record
// consumes exactly 8 body bytes and gives one marker with rsp_tuser high,
// rsp_tdata zero and rsp_tlast high. All other content and all padding
// bytes are consumed silently.
// Throughput is one byte per cycle while the queue is not full. A result
// reaches rsp_ through a 4-entry queue, which the parser writes on the input
// transfer that caused it, and the output register, which loads from the queue.
// When the receiver stalls, results collect in the queue and in the output
// register; req_tready falls only once the queue is full.
// Reset clears the parser to the start of a header and empties the queue
// and output register.
`default_nettype none

module record_stream_deframer (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] stream_byte
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic       rsp_tuser,   // [0] result_kind
   output logic       rsp_tlast    // last_in_record
);
   import rsd_pkg::*;

   logic          push;
   logic          pop;
   rsd_item_type  push_item;
   rsd_item_type  pop_item;
   rsd_item_type  out_item;
   rsd_qstat_type qstat;

   rsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .queue_full (qstat.full),
      .byte_ready (req_tready),
      .push       (push),
      .push_item  (push_item)
   );

   rsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (qstat)
   );

   rsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (qstat),
      .pop_item  (pop_item),
      .pop       (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item)
   );

   assign rsp_tdata = out_item.data;
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule

`default_nettype wire

// ===== verif/record_stream_deframer_tb.sv =====
// Self-checking testbench for the record stream deframer, with a built-in record parser model.
`default_nettype none

module record_stream_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rsd_pkg::*;

   // Record type that the block drops silently.
   localparam logic [7:0] KIND_STDERR = 8'd7;
   // Run limit: covers the long record and every random transfer with idling.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Cycles to wait after the last result before stopping or changing phase.
   localparam int SETTLE_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   // Percent chances of an idle sender cycle and a stalled receiver cycle.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   int bytes_sent = 0;

   // Results that the parser model expects, oldest first.
   rsd_item_type pending_results[$];

   // Parser model state.
   logic [1:0]  model_phase = PH_HEADER;
   logic [2:0]  model_hpos = 3'd0;
   logic [7:0]  model_kind = 8'd0;
   logic [7:0]  model_len_hi = 8'd0;
   logic [15:0] model_content_left = 16'd0;
   logic [7:0]  model_pad_left = 8'd0;

   record_stream_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Model of the parser: advance by one accepted byte and queue any result.
   task automatic parse_byte(input logic [7:0] b);
      logic done;
      begin
         case (model_phase)
            PH_CONTENT: begin
               model_content_left = model_content_left - 16'd1;
               done = (model_content_left == 16'd0);
               if (model_kind == KIND_STDOUT)
                  pending_results.push_back('{kind: RES_BYTE, data: b, last: done});
               else if (model_kind == KIND_END_REQUEST && done)
                  pending_results.push_back('{kind: RES_END, data: 8'h00, last: 1'b1});
               if (done)
                  model_phase = (model_pad_left != 8'd0) ? PH_PADDING : PH_HEADER;
            end
            PH_PADDING: begin
               model_pad_left = model_pad_left - 8'd1;
               if (model_pad_left == 8'd0)
                  model_phase = PH_HEADER;
            end
            default: begin
               // Header bytes; an unused phase value parses as a header too.
               model_phase = PH_HEADER;
               case (model_hpos)
                  HPOS_KIND:   model_kind = b;
                  HPOS_LEN_HI: model_len_hi = b;
                  HPOS_LEN_LO: model_content_left = {model_len_hi, b};
                  HPOS_PAD:    model_pad_left = b;
                  default: ;
               endcase
               if (model_hpos == HPOS_LAST) begin
                  model_hpos = 3'd0;
                  if (model_kind == KIND_END_REQUEST)
                     model_content_left = END_BODY_BYTES;
                  if (model_content_left != 16'd0)
                     model_phase = PH_CONTENT;
                  else
                     model_phase = (model_pad_left != 8'd0) ? PH_PADDING : PH_HEADER;
               end else begin
                  model_hpos = model_hpos + 3'd1;
               end
            end
         endcase
      end
   endtask

   // Receiver: random stalls, and a check of each result transfer.
   always @(posedge clock) begin
      rsd_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: tuser=%0d tdata=%02h tlast=%0d",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== want.data) begin
               $error("data_byte: expected %02h, got %02h", want.data, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_in_record: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Send one stream byte, update the model on the transfer, then maybe idle.
   task automatic send_byte(input logic [7:0] b);
      begin
         req_tvalid <= 1'b1;
         req_tdata <= b;
         do @(posedge clock); while (!req_tready);
         parse_byte(b);
         bytes_sent++;
         while ($urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Eight header bytes; version, request id and reserved are random.
   task automatic send_header(input logic [7:0] kind, input logic [15:0] len,
                              input logic [7:0] pad);
      begin
         send_byte(8'($urandom()));
         send_byte(kind);
         send_byte(8'($urandom()));
         send_byte(8'($urandom()));
         send_byte(len[15:8]);
         send_byte(len[7:0]);
         send_byte(pad);
         send_byte(8'($urandom()));
      end
   endtask

   // Whole record with random content and padding bytes.
   task automatic send_record(input logic [7:0] kind, input logic [15:0] len,
                              input logic [7:0] pad);
      int body;
      begin
         body = (kind == KIND_END_REQUEST) ? int'(END_BODY_BYTES) : int'(len);
         send_header(kind, len, pad);
         repeat (body) send_byte(8'($urandom()));
         repeat (int'(pad)) send_byte(8'($urandom()));
      end
   endtask

   // Hold the sender until every expected result has arrived.
   task automatic drain_results();
      begin
         req_tvalid <= 1'b0;
         while (pending_results.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   // STDOUT records with extreme content bytes.
   task automatic test_stdout_records();
      begin
         send_header(KIND_STDOUT, 16'd1, 8'd0);
         send_byte(8'hFF);
         send_header(KIND_STDOUT, 16'd2, 8'd1);
         send_byte(8'h00);
         send_byte(8'h80);
         send_byte(8'h5A);
      end
   endtask

   // Empty STDOUT records, with and without padding, give no result.
   task automatic test_empty_records();
      begin
         send_record(KIND_STDOUT, 16'd0, 8'd0);
         send_record(KIND_STDOUT, 16'd0, 8'd2);
      end
   endtask

   // End of request ignores its declared length and takes eight body bytes.
   task automatic test_end_request();
      begin
         send_record(KIND_END_REQUEST, 16'hFFFF, 8'd1);
         send_record(KIND_END_REQUEST, 16'h0000, 8'd0);
      end
   endtask

   // STDERR and unknown record types are dropped, padding included; a STDOUT record follows them.
   task automatic test_dropped_records();
      begin
         send_record(KIND_STDERR, 16'd2, 8'd0);
         send_record(8'hFF, 16'd1, 8'd3);
         send_record(8'h00, 16'd0, 8'd1);
         send_record(KIND_STDOUT, 16'd1, 8'd0);
      end
   endtask

   // Receiver stalls while a record streams in, then the sender waits it out.
   task automatic test_pause_until_drained();
      begin
         recv_stall_pct = 90;
         send_record(KIND_STDOUT, 16'd12, 8'd0);
         drain_results();
         recv_stall_pct = 0;
      end
   endtask

   // Content lengths that use the high length byte, and full padding, sent without idling.
   task automatic test_long_records();
      begin
         send_record(KIND_STDERR, 16'h0100, 8'd0);
         send_record(KIND_STDOUT, 16'h0101, 8'hFF);
         drain_results();
      end
   endtask

   // Random well-formed records under one idling mix.
   task automatic test_random_records(input int n_bytes, input int idle_pct,
                                      input int stall_pct);
      int start;
      int pick;
      logic [7:0] kind;
      logic [15:0] len;
      logic [7:0] pad;
      begin
         send_idle_pct = idle_pct;
         recv_stall_pct = stall_pct;
         start = bytes_sent;
         while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 50)      kind = KIND_STDOUT;
            else if (pick < 65) kind = KIND_END_REQUEST;
            else if (pick < 80) kind = KIND_STDERR;
            else                kind = 8'($urandom());
            pick = $urandom_range(99);
            if (kind == KIND_END_REQUEST) len = 16'($urandom());
            else if (pick < 85)           len = 16'($urandom_range(12));
            else if (pick < 97)           len = 16'($urandom_range(64, 13));
            else                          len = 16'($urandom_range(300, 65));
            pick = $urandom_range(99);
            if (pick < 97) pad = 8'($urandom_range(8));
            else           pad = 8'($urandom_range(255, 9));
            send_record(kind, len, pad);
         end
         drain_results();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_stdout_records();
      test_empty_records();
      test_end_request();
      test_dropped_records();
      test_pause_until_drained();
      test_long_records();
      test_random_records(250, 0, 0);
      test_random_records(250, 67, 0);
      test_random_records(250, 0, 67);
      test_random_records(250, 28, 28);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
